/* hw/rtl/rra_pkg.sv */
package rra_pkg;

    localparam int SQRT_STEPS = 21;
    localparam int RAD_W      = 2 * SQRT_STEPS;
    localparam int ROOT_W     = SQRT_STEPS;
    localparam int FIFO_DEPTH = 32;
    localparam int FIFO_AW    = 5;
    localparam int LEVEL_W    = 6;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RECT_LEFT,
        CFG_RECT_TOP,
        CFG_RECT_WIDTH,
        CFG_RECT_HEIGHT,
        CFG_CORNER_RADIUS,
        CFG_FILL_COLOR
    } cfg_index_t;

    typedef struct packed {
        logic signed [15:0] rect_left;
        logic signed [15:0] rect_top;
        logic [14:0]        rect_width;
        logic [14:0]        rect_height;
        logic [13:0]        corner_radius;
        logic [15:0]        fill_color;
    } cfg_t;

    typedef struct packed {
        logic signed [11:0] column;
        logic signed [11:0] row;
        logic [15:0]        old_pixel;
    } pixel_in_t;

    typedef struct packed {
        logic [15:0] new_pixel;
        logic        write_enable;
        logic [8:0]  coverage;
    } pixel_out_t;

    // per-pixel data riding alongside the root extraction
    typedef struct packed {
        logic               on_screen;
        logic               corner;
        logic signed [18:0] metric;
        logic [15:0]        old_pixel;
    } side_t;

    typedef struct packed {
        logic [RAD_W-1:0] rem;
        logic [RAD_W-1:0] root;
        side_t            side;
    } sqrt_data_t;

    // radius in 1/32 px: min(2*corner_radius, width, height)
    function automatic logic [14:0] clamp_radius(cfg_t c);
        logic [14:0] r;
        r = {c.corner_radius, 1'b0};
        if (r > c.rect_width) r = c.rect_width;
        if (r > c.rect_height) r = c.rect_height;
        return r;
    endfunction

endpackage

/* hw/rtl/rra_geom.sv */
module rra_geom #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rra_pkg::cfg_t          cfg,
    input  logic                   in_take,
    input  rra_pkg::pixel_in_t     in_word,
    output logic                   sq_valid,
    output rra_pkg::sqrt_data_t    sq_data
);
    import rra_pkg::*;

    logic [14:0]        r2;
    logic [14:0]        edge_x;
    logic [14:0]        edge_y;
    logic signed [17:0] cx;
    logic signed [17:0] cy;
    logic signed [18:0] px;
    logic signed [18:0] py;
    logic [18:0]        negx;
    logic [18:0]        negy;
    logic [17:0]        absx;
    logic [17:0]        absy;
    logic signed [18:0] qx;
    logic signed [18:0] qy;
    logic signed [18:0] qmax;
    side_t              side_next;

    logic               valid1_reg;
    side_t              side1_reg;
    logic [17:0]        qx1_reg;
    logic [17:0]        qy1_reg;

    logic               valid2_reg;
    side_t              side2_reg;
    logic [35:0]        sqx2_reg;
    logic [35:0]        sqy2_reg;

    logic               valid3_reg;
    side_t              side3_reg;
    logic [RAD_W-1:0]   rad3_reg;
    logic [36:0]        sum_next;

    assign r2     = clamp_radius(cfg);
    assign edge_x = cfg.rect_width - r2;
    assign edge_y = cfg.rect_height - r2;
    assign cx     = $signed({cfg.rect_left[15], cfg.rect_left, 1'b0})
                  + $signed({3'b000, cfg.rect_width});
    assign cy     = $signed({cfg.rect_top[15], cfg.rect_top, 1'b0})
                  + $signed({3'b000, cfg.rect_height});
    assign px     = $signed({{2{in_word.column[11]}}, in_word.column, 5'd16})
                  - $signed({cx[17], cx});
    assign py     = $signed({{2{in_word.row[11]}}, in_word.row, 5'd16})
                  - $signed({cy[17], cy});
    assign negx   = -px;
    assign negy   = -py;
    assign absx   = px[18] ? negx[17:0] : px[17:0];
    assign absy   = py[18] ? negy[17:0] : py[17:0];
    assign qx     = $signed({1'b0, absx}) - $signed({4'b0000, edge_x});
    assign qy     = $signed({1'b0, absy}) - $signed({4'b0000, edge_y});
    assign qmax   = (qx > qy) ? qx : qy;

    always_comb
    begin
        side_next.on_screen = !in_word.column[11]
                            && (in_word.column[10:0] < 11'(SCREEN_WIDTH))
                            && !in_word.row[11]
                            && (in_word.row[10:0] < 11'(SCREEN_HEIGHT));
        side_next.corner    = !qx[18] && (qx != '0) && !qy[18] && (qy != '0);
        side_next.metric    = qmax - $signed({4'b0000, r2});
        side_next.old_pixel = in_word.old_pixel;
    end

    assign sum_next = {1'b0, sqx2_reg} + {1'b0, sqy2_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid1_reg <= 1'b0;
            valid2_reg <= 1'b0;
            valid3_reg <= 1'b0;
        end
        else
        begin
            valid1_reg <= in_take;
            valid2_reg <= valid1_reg;
            valid3_reg <= valid2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        side1_reg <= side_next;
        qx1_reg   <= qx[17:0];
        qy1_reg   <= qy[17:0];
        side2_reg <= side1_reg;
        sqx2_reg  <= qx1_reg * qx1_reg;
        sqy2_reg  <= qy1_reg * qy1_reg;
        side3_reg <= side2_reg;
        // corner sum of squares stays below 2^36
        rad3_reg  <= {sum_next[35:0], 6'b000000};
    end

    assign sq_valid     = valid3_reg;
    assign sq_data.rem  = rad3_reg;
    assign sq_data.root = '0;
    assign sq_data.side = side3_reg;

endmodule

/* hw/rtl/rra_sqrt_cell.sv */
module rra_sqrt_cell #(
    parameter int BIT_POS = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    input  rra_pkg::sqrt_data_t  in_data,
    output logic                 out_valid,
    output rra_pkg::sqrt_data_t  out_data
);
    import rra_pkg::*;

    localparam logic [RAD_W-1:0] BIT_VAL = RAD_W'(1) << BIT_POS;

    logic [RAD_W-1:0] trial;
    logic             valid_reg;
    sqrt_data_t       data_reg;
    sqrt_data_t       data_next;

    assign trial = in_data.root + BIT_VAL;

    always_comb
    begin
        data_next = in_data;
        if (in_data.rem >= trial)
        begin
            data_next.rem  = in_data.rem - trial;
            data_next.root = (in_data.root >> 1) + BIT_VAL;
        end
        else
        begin
            data_next.root = in_data.root >> 1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

/* hw/rtl/rra_shade.sv */
module rra_shade (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rra_pkg::cfg_t        cfg,
    input  logic                 sq_valid,
    input  rra_pkg::sqrt_data_t  sq_data,
    output logic                 out_valid,
    output rra_pkg::pixel_out_t  out_word
);
    import rra_pkg::*;

    logic [14:0]        r2;
    logic signed [22:0] d_corner;
    logic signed [22:0] d_edge;
    logic signed [22:0] distance;
    logic signed [22:0] diff;
    logic [8:0]         cov_next;
    logic [9:0]         kbias;
    logic [5:0]         k_next;
    logic [5:0]         kinv;

    logic               valid_a_reg;
    logic [8:0]         cov_a_reg;
    logic               we_a_reg;
    logic [15:0]        old_a_reg;
    logic [5:0]         k_a_reg;

    logic               valid_b_reg;
    logic [8:0]         cov_b_reg;
    logic               we_b_reg;
    logic [15:0]        old_b_reg;
    logic [10:0]        fr_b_reg;
    logic [10:0]        br_b_reg;
    logic [11:0]        fg_b_reg;
    logic [11:0]        bg_b_reg;
    logic [10:0]        fb_b_reg;
    logic [10:0]        bb_b_reg;

    logic [9:0]         red_sum;
    logic [10:0]        grn_sum;
    logic [9:0]         blu_sum;
    logic               valid_c_reg;
    pixel_out_t         word_c_reg;
    pixel_out_t         word_next;

    assign r2       = clamp_radius(cfg);
    assign d_corner = $signed({2'b00, sq_data.root[ROOT_W-1:0]})
                    - $signed({5'b00000, r2, 3'b000});
    assign d_edge   = $signed({sq_data.side.metric[18], sq_data.side.metric, 3'b000});
    assign distance = sq_data.side.corner ? d_corner : d_edge;
    assign diff     = 23'sd128 - distance;

    always_comb
    begin
        priority if (distance <= -23'sd128)
            cov_next = 9'd256;
        else if (distance >= 23'sd128)
            cov_next = '0;
        else
            cov_next = diff[8:0];
    end

    assign kbias  = {1'b0, cov_next} + 10'd4;
    assign k_next = kbias[8:3];
    assign kinv   = 6'd32 - k_a_reg;

    assign red_sum   = 10'(fr_b_reg + br_b_reg);
    assign grn_sum   = 11'(fg_b_reg + bg_b_reg);
    assign blu_sum   = 10'(fb_b_reg + bb_b_reg);

    always_comb
    begin
        word_next.coverage     = cov_b_reg;
        word_next.write_enable = we_b_reg;
        word_next.new_pixel    = we_b_reg ? {red_sum[9:5], grn_sum[10:5], blu_sum[9:5]}
                                          : old_b_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_a_reg <= 1'b0;
            valid_b_reg <= 1'b0;
            valid_c_reg <= 1'b0;
        end
        else
        begin
            valid_a_reg <= sq_valid;
            valid_b_reg <= valid_a_reg;
            valid_c_reg <= valid_b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        cov_a_reg  <= cov_next;
        we_a_reg   <= sq_data.side.on_screen && (cov_next != '0);
        old_a_reg  <= sq_data.side.old_pixel;
        k_a_reg    <= k_next;

        cov_b_reg  <= cov_a_reg;
        we_b_reg   <= we_a_reg;
        old_b_reg  <= old_a_reg;
        fr_b_reg   <= 11'(cfg.fill_color[15:11]) * 11'(k_a_reg);
        br_b_reg   <= 11'(old_a_reg[15:11]) * 11'(kinv);
        fg_b_reg   <= 12'(cfg.fill_color[10:5]) * 12'(k_a_reg);
        bg_b_reg   <= 12'(old_a_reg[10:5]) * 12'(kinv);
        fb_b_reg   <= 11'(cfg.fill_color[4:0]) * 11'(k_a_reg);
        bb_b_reg   <= 11'(old_a_reg[4:0]) * 11'(kinv);

        word_c_reg <= word_next;
    end

    assign out_valid = valid_c_reg;
    assign out_word  = word_c_reg;

endmodule

/* hw/rtl/rra_out_fifo.sv */
module rra_out_fifo (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_valid,
    input  rra_pkg::pixel_out_t  wr_word,
    output logic                 rd_valid,
    input  logic                 rd_ready,
    output rra_pkg::pixel_out_t  rd_word
);
    import rra_pkg::*;

    pixel_out_t           mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg;
    logic [FIFO_AW-1:0]   rd_ptr_reg;
    logic [LEVEL_W-1:0]   level_reg;
    logic [LEVEL_W-1:0]   level_next;
    logic                 head_valid_reg;
    logic                 head_valid_next;
    pixel_out_t           head_word_reg;
    logic                 rd_take;
    logic                 mem_pop;

    // head register in front of the memory holds the word on offer
    assign rd_valid = head_valid_reg;
    assign rd_word  = head_word_reg;
    assign rd_take  = head_valid_reg && rd_ready;
    assign mem_pop  = (level_reg != '0) && (!head_valid_reg || rd_take);

    always_comb
    begin
        level_next = level_reg;
        if (wr_valid && !mem_pop)
            level_next = level_reg + 1'b1;
        else if (!wr_valid && mem_pop)
            level_next = level_reg - 1'b1;

        head_valid_next = head_valid_reg;
        if (mem_pop)
            head_valid_next = 1'b1;
        else if (rd_take)
            head_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg     <= '0;
            rd_ptr_reg     <= '0;
            level_reg      <= '0;
            head_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_valid)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (mem_pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            level_reg      <= level_next;
            head_valid_reg <= head_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_valid)
            mem[wr_ptr_reg] <= wr_word;
        if (mem_pop)
            head_word_reg <= mem[rd_ptr_reg];
    end

endmodule

/* hw/rtl/rounded_rect_aa_pixel_shader.sv */
// channel  dir  handshake                 word
// cfg      in   cfg_write                 cfg_index, cfg_data
// in       in   in_valid / in_ready       in_word (column, row, old_pixel)
// out      out  out_valid / out_ready     out_word (new_pixel, write_enable, coverage)
//
// One pixel per clock while in_ready is high. The path to the output queue has three
// geometry stages, a 21-cell square-root chain and three coverage/blend stages. The
// queue reads through a head register, so a word is offered from that register.
// The 32-word output queue is guarded by an in-flight count, so a stalled
// out_ready only drops in_ready once 32 words are in flight.
// Reset clears control and sets the configuration to zero; data registers are not reset.
module rounded_rect_aa_pixel_shader #(
    parameter int SCREEN_WIDTH  = 320,
    parameter int SCREEN_HEIGHT = 240
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [rra_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rra_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                               in_valid,
    output logic                               in_ready,
    input  rra_pkg::pixel_in_t                 in_word,
    output logic                               out_valid,
    input  logic                               out_ready,
    output rra_pkg::pixel_out_t                out_word
);
    import rra_pkg::*;

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic [LEVEL_W-1:0]   inflight_reg;
    logic [LEVEL_W-1:0]   inflight_next;
    logic                 in_take;
    logic                 out_take;

    logic                 chain_valid [SQRT_STEPS+1];
    sqrt_data_t           chain_data  [SQRT_STEPS+1];

    logic                 shade_valid;
    pixel_out_t           shade_word;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_RECT_LEFT:     cfg_next.rect_left     = $signed(cfg_data);
                CFG_RECT_TOP:      cfg_next.rect_top      = $signed(cfg_data);
                CFG_RECT_WIDTH:    cfg_next.rect_width    = cfg_data[14:0];
                CFG_RECT_HEIGHT:   cfg_next.rect_height   = cfg_data[14:0];
                CFG_CORNER_RADIUS: cfg_next.corner_radius = cfg_data[13:0];
                CFG_FILL_COLOR:    cfg_next.fill_color    = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    assign in_ready = (inflight_reg < LEVEL_W'(FIFO_DEPTH));
    assign in_take  = in_valid && in_ready;
    assign out_take = out_valid && out_ready;

    always_comb
    begin
        inflight_next = inflight_reg;
        if (in_take && !out_take)
            inflight_next = inflight_reg + 1'b1;
        else if (!in_take && out_take)
            inflight_next = inflight_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg      <= '0;
            inflight_reg <= '0;
        end
        else
        begin
            cfg_reg      <= cfg_next;
            inflight_reg <= inflight_next;
        end
    end

    rra_geom #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_geom (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .in_take  (in_take),
        .in_word  (in_word),
        .sq_valid (chain_valid[0]),
        .sq_data  (chain_data[0])
    );

    for (genvar i = 0; i < SQRT_STEPS; i++)
    begin : g_cell
        rra_sqrt_cell #(
            .BIT_POS (2 * (SQRT_STEPS - 1 - i))
        ) u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    rra_shade u_shade (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .sq_valid  (chain_valid[SQRT_STEPS]),
        .sq_data   (chain_data[SQRT_STEPS]),
        .out_valid (shade_valid),
        .out_word  (shade_word)
    );

    rra_out_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (shade_valid),
        .wr_word  (shade_word),
        .rd_valid (out_valid),
        .rd_ready (out_ready),
        .rd_word  (out_word)
    );

endmodule

/* verif/rounded_rect_aa_pixel_shader_test.sv */
`timescale 1ns / 1ps

module rounded_rect_aa_pixel_shader_test;

    import rra_pkg::*;

    localparam int SCREEN_W       = 320;
    localparam int SCREEN_H       = 240;
    localparam int PIPE_LATENCY   = 29;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int N_PROBES       = 24;
    localparam int N_SETS         = 6;
    localparam int N_PHASES       = 11;
    localparam int PHASE_PIXELS   = 150;

    localparam int          FULL_COVER  = 256;
    localparam int          EDGE_SPAN   = 128;
    localparam int          BLEND_ONE   = 32;
    localparam int          BLEND_ROUND = 4;
    localparam logic [31:0] SPREAD_MASK = 32'h07E0F81F;

    typedef struct packed {
        logic [15:0] left;
        logic [15:0] top;
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] radius;
        logic [15:0] fill;
    } shape_regs_t;

    typedef struct packed {
        int                 shape;
        logic signed [11:0] column;
        logic signed [11:0] row;
        logic [15:0]        old_pixel;
        bit                 typed;
        pixel_out_t         want;
    } probe_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_write;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  in_valid;
    logic                  in_ready;
    pixel_in_t             in_word;
    logic                  out_valid;
    logic                  out_ready;
    pixel_out_t            out_word;

    cfg_t        live_cfg;
    shape_regs_t live_shape;
    pixel_out_t  pending_pixels[$];
    pixel_out_t  head;
    probe_t      probes[N_PROBES];
    shape_regs_t shape_sets[N_SETS];
    bit          calm;
    int          fail_count;
    int          idle_cycles;
    int          shaded_total;
    int          written_total;
    int          partial_total;
    int          hidden_total;
    int          settings_total;

    rounded_rect_aa_pixel_shader #(
        .SCREEN_WIDTH (SCREEN_W),
        .SCREEN_HEIGHT(SCREEN_H)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_write(cfg_write),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_word  (in_word),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_word (out_word)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
    end

    function automatic longint unsigned floor_root(longint unsigned v);
        longint unsigned rem;
        longint unsigned res;
        longint unsigned probe_bit;
        rem = v;
        res = 0;
        probe_bit = 64'd1 << 62;
        while (probe_bit > rem)
            probe_bit >>= 2;
        while (probe_bit != 0)
        begin
            if (rem >= res + probe_bit)
            begin
                rem -= res + probe_bit;
                res = (res >> 1) + probe_bit;
            end
            else
                res >>= 1;
            probe_bit >>= 2;
        end
        return res;
    endfunction

    function automatic logic [15:0] mix565(logic [15:0] bg, logic [15:0] fg, int unsigned cov);
        logic [31:0] b;
        logic [31:0] f;
        logic [31:0] k;
        logic [31:0] r;
        b = {bg, bg} & SPREAD_MASK;
        f = {fg, fg} & SPREAD_MASK;
        k = (cov + BLEND_ROUND) >> 3;
        r = ((f * k + b * (BLEND_ONE - k)) >> 5) & SPREAD_MASK;
        return r[15:0] | r[31:16];
    endfunction

    function automatic pixel_out_t shade_pixel(cfg_t c, pixel_in_t p);
        longint half_w;
        longint half_h;
        longint rad;
        longint col;
        longint row;
        longint dx;
        longint dy;
        longint qx;
        longint qy;
        longint distance;
        longint unsigned sq;
        int unsigned cov;
        logic on_screen;
        pixel_out_t res;
        half_w = longint'(c.rect_width);
        half_h = longint'(c.rect_height);
        rad = 2 * longint'(c.corner_radius);
        if (rad > half_w)
            rad = half_w;
        if (rad > half_h)
            rad = half_h;
        col = longint'($signed(p.column));
        row = longint'($signed(p.row));
        dx = 32 * col + 16 - (2 * longint'($signed(c.rect_left)) + half_w);
        dy = 32 * row + 16 - (2 * longint'($signed(c.rect_top)) + half_h);
        qx = (dx < 0 ? -dx : dx) - (half_w - rad);
        qy = (dy < 0 ? -dy : dy) - (half_h - rad);
        if (qx > 0 && qy > 0)
        begin
            sq = longint'(qx * qx + qy * qy);
            distance = longint'(floor_root(sq * 64)) - 8 * rad;
        end
        else
            distance = 8 * ((qx > qy ? qx : qy) - rad);
        if (distance <= -EDGE_SPAN)
            cov = FULL_COVER;
        else if (distance >= EDGE_SPAN)
            cov = 0;
        else
            cov = int'(EDGE_SPAN - distance);
        on_screen = col >= 0 && col < SCREEN_W && row >= 0 && row < SCREEN_H;
        res.coverage = cov[8:0];
        res.write_enable = on_screen && cov > 0;
        if (!res.write_enable)
            res.new_pixel = p.old_pixel;
        else if (cov >= FULL_COVER)
            res.new_pixel = c.fill_color;
        else
            res.new_pixel = mix565(p.old_pixel, c.fill_color, cov);
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic signed [11:0] clip12(int v);
        if (v < -2048)
            return 12'h800;
        if (v > 2047)
            return 12'h7FF;
        return v[11:0];
    endfunction

    function automatic shape_regs_t random_shape();
        int sel;
        int span;
        shape_regs_t s;
        sel = $urandom_range(0, 9);
        if (sel == 0)
        begin
            s.left   = 16'($urandom);
            s.top    = 16'($urandom);
            s.width  = 16'($urandom);
            s.height = 16'($urandom);
            s.radius = 16'($urandom);
        end
        else
        begin
            span = sel < 3 ? 12 : 150;
            s.left   = 16'(int'($urandom_range(0, 16 * 360)) - 16 * 20);
            s.top    = 16'(int'($urandom_range(0, 16 * 280)) - 16 * 20);
            s.width  = 16'($urandom_range(0, 16 * span));
            s.height = 16'($urandom_range(0, 16 * span));
            s.radius = 16'($urandom_range(0, 16 * (sel < 5 ? 4 : 40)));
        end
        s.fill = 16'($urandom);
        return s;
    endfunction

    function automatic pixel_in_t random_pixel(shape_regs_t s);
        int sel;
        int lo_c;
        int hi_c;
        int lo_r;
        int hi_r;
        pixel_in_t p;
        sel = $urandom_range(0, 9);
        p.old_pixel = 16'($urandom);
        if (sel < 7)
        begin
            lo_c = ($signed(s.left) >>> 4) - 3;
            hi_c = (($signed(s.left) + int'(s.width[14:0])) >>> 4) + 3;
            lo_r = ($signed(s.top) >>> 4) - 3;
            hi_r = (($signed(s.top) + int'(s.height[14:0])) >>> 4) + 3;
            p.column = clip12(int'($urandom_range(0, hi_c - lo_c)) + lo_c);
            p.row    = clip12(int'($urandom_range(0, hi_r - lo_r)) + lo_r);
        end
        else if (sel < 9)
        begin
            p.column = $urandom_range(0, 1) ? clip12(int'($urandom_range(0, 4)) - 2)
                                            : clip12(SCREEN_W - 3 + int'($urandom_range(0, 4)));
            p.row    = $urandom_range(0, 1) ? clip12(int'($urandom_range(0, 4)) - 2)
                                            : clip12(SCREEN_H - 3 + int'($urandom_range(0, 4)));
        end
        else
        begin
            p.column = 12'($urandom);
            p.row    = 12'($urandom);
        end
        return p;
    endfunction

    task automatic load_shape(input shape_regs_t s);
        cfg_index_t  reg_sel;
        logic [15:0] val;
        for (int i = 0; i < reg_sel.num(); i++)
        begin
            reg_sel = cfg_index_t'(i);
            case (reg_sel)
                CFG_RECT_LEFT:
                begin
                    val = s.left;
                    live_cfg.rect_left = s.left;
                end
                CFG_RECT_TOP:
                begin
                    val = s.top;
                    live_cfg.rect_top = s.top;
                end
                CFG_RECT_WIDTH:
                begin
                    val = s.width;
                    live_cfg.rect_width = s.width[14:0];
                end
                CFG_RECT_HEIGHT:
                begin
                    val = s.height;
                    live_cfg.rect_height = s.height[14:0];
                end
                CFG_CORNER_RADIUS:
                begin
                    val = s.radius;
                    live_cfg.corner_radius = s.radius[13:0];
                end
                default:
                begin
                    val = s.fill;
                    live_cfg.fill_color = s.fill;
                end
            endcase
            cfg_write <= 1'b1;
            cfg_index <= reg_sel;
            cfg_data  <= val;
            @(posedge clk);
        end
        cfg_write <= 1'b0;
        live_shape = s;
        settings_total++;
    endtask

    task automatic drain_pipe();
        in_valid <= 1'b0;
        while (pending_pixels.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_pixel(input pixel_in_t w, input bit typed, input pixel_out_t want);
        int gap;
        pixel_out_t exp_word;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        exp_word = typed ? want : shade_pixel(live_cfg, w);
        pending_pixels.push_back(exp_word);
        shaded_total++;
        if (exp_word.write_enable)
            written_total++;
        if (exp_word.coverage != 0 && exp_word.coverage != FULL_COVER)
            partial_total++;
        if (!exp_word.write_enable && exp_word.coverage != 0)
            hidden_total++;
    endtask

    // output side stalls
    initial
    begin
        int hold;
        hold = 0;
        out_ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold > 0)
            begin
                hold--;
                out_ready <= 1'b0;
            end
            else
            begin
                hold = pick_gap();
                out_ready <= (hold == 0);
                if (hold > 0)
                    hold--;
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_pixels.size() == 0)
            begin
                $error("output word with nothing pending: %h", out_word);
                fail_count++;
            end
            else
            begin
                head = pending_pixels.pop_front();
                if (out_word.new_pixel !== head.new_pixel)
                begin
                    $error("new_pixel: expected %h, got %h", head.new_pixel, out_word.new_pixel);
                    fail_count++;
                end
                if (out_word.write_enable !== head.write_enable)
                begin
                    $error("write_enable: expected %b, got %b",
                           head.write_enable, out_word.write_enable);
                    fail_count++;
                end
                if (out_word.coverage !== head.coverage)
                begin
                    $error("coverage: expected %0d, got %0d", head.coverage, out_word.coverage);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_ready) || (out_valid && out_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        int current_set;
        pixel_in_t w;
        in_valid  <= 1'b0;
        in_word   <= '0;
        cfg_write <= 1'b0;
        cfg_index <= CFG_RECT_LEFT;
        cfg_data  <= '0;
        calm = 1'b0;
        live_cfg = '0;
        live_shape = '0;
        fail_count = 0;
        shaded_total = 0;
        written_total = 0;
        partial_total = 0;
        hidden_total = 0;
        settings_total = 0;

        // set 0 is the reset state and is never written
        shape_sets = '{
            '{16'h0000, 16'h0000, 16'd0,    16'd0,    16'd0,    16'h0000},
            '{16'h0000, 16'h0000, 16'd5120, 16'd3840, 16'd0,    16'hF800},
            '{16'd325,  16'd483,  16'd1607, 16'd809,  16'd321,  16'h07E0},
            '{16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
            '{16'd800,  16'd800,  16'd0,    16'd0,    16'd100,  16'h001F},
            '{16'hFF60, 16'hFF60, 16'd640,  16'd640,  16'd0,    16'h1234}
        };

        probes = '{
            '{0, 12'sd0,   12'sd0,   16'h0000, 1'b1, '{16'h0000, 1'b0, 9'd0}},
            '{0, 12'h800,  12'h800,  16'hFFFF, 1'b1, '{16'hFFFF, 1'b0, 9'd0}},
            '{0, 12'h7FF,  12'h7FF,  16'hA5A5, 1'b1, '{16'hA5A5, 1'b0, 9'd0}},
            '{0, 12'sd319, 12'sd239, 16'h5A5A, 1'b1, '{16'h5A5A, 1'b0, 9'd0}},
            '{1, 12'sd10,  12'sd10,  16'h1234, 1'b1, '{16'hF800, 1'b1, 9'd256}},
            '{1, 12'sd0,   12'sd0,   16'h0000, 1'b1, '{16'hF800, 1'b1, 9'd256}},
            '{1, 12'sd319, 12'sd239, 16'hFFFF, 1'b1, '{16'hF800, 1'b1, 9'd256}},
            '{1, 12'sd320, 12'sd100, 16'h0F0F, 1'b1, '{16'h0F0F, 1'b0, 9'd0}},
            '{1, 12'sd100, -12'sd1,  16'h0F0F, 1'b1, '{16'h0F0F, 1'b0, 9'd0}},
            '{2, 12'sd20,  12'sd30,  16'hFFFF, 1'b0, '0},
            '{2, 12'sd21,  12'sd31,  16'h0000, 1'b0, '0},
            '{2, 12'sd22,  12'sd32,  16'hF81F, 1'b0, '0},
            '{2, 12'sd70,  12'sd30,  16'h8410, 1'b0, '0},
            '{2, 12'sd20,  12'sd55,  16'h7BEF, 1'b0, '0},
            '{2, 12'sd120, 12'sd80,  16'hFFFF, 1'b0, '0},
            '{2, 12'sd70,  12'sd55,  16'h0000, 1'b0, '0},
            '{2, 12'sd60,  12'sd80,  16'h001F, 1'b0, '0},
            '{3, 12'h800,  12'h7FF,  16'h0000, 1'b0, '0},
            '{3, 12'h7FF,  12'h800,  16'hFFFF, 1'b0, '0},
            '{3, 12'sd0,   12'sd0,   16'h8000, 1'b0, '0},
            '{4, 12'sd50,  12'sd50,  16'h4321, 1'b0, '0},
            '{4, 12'sd49,  12'sd49,  16'h1357, 1'b0, '0},
            '{5, -12'sd5,  -12'sd5,  16'hBEEF, 1'b1, '{16'hBEEF, 1'b0, 9'd256}},
            '{5, 12'sd5,   12'sd5,   16'h0000, 1'b1, '{16'h1234, 1'b1, 9'd256}}
        };

        wait (rst_n === 1'b1);
        @(posedge clk);

        current_set = 0;
        foreach (probes[i])
        begin
            if (probes[i].shape != current_set)
            begin
                drain_pipe();
                current_set = probes[i].shape;
                load_shape(shape_sets[current_set]);
            end
            w.column    = probes[i].column;
            w.row       = probes[i].row;
            w.old_pixel = probes[i].old_pixel;
            send_pixel(w, probes[i].typed, probes[i].want);
        end

        for (int phase = 0; phase < N_PHASES; phase++)
        begin
            drain_pipe();
            calm = (phase % 4 == 2);
            load_shape(random_shape());
            repeat (PHASE_PIXELS)
                send_pixel(random_pixel(live_shape), 1'b0, '0);
        end

        drain_pipe();
        repeat (2 * PIPE_LATENCY) @(posedge clk);

        $display("Shaded %0d pixels over %0d register settings: %0d written, %0d partly covered,",
                 shaded_total, settings_total, written_total, partial_total);
        $display("%0d covered but off screen, %0d mismatches.", hidden_total, fail_count);
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

/* sim.f */
hw/rtl/rra_pkg.sv
hw/rtl/rra_geom.sv
hw/rtl/rra_sqrt_cell.sv
hw/rtl/rra_shade.sv
hw/rtl/rra_out_fifo.sv
hw/rtl/rounded_rect_aa_pixel_shader.sv
verif/rounded_rect_aa_pixel_shader_test.sv
